// ===== rtl/fvn_pkg.sv =====
// Shared types and constants of the fractal value noise block.
`default_nettype none

package fvn_pkg;

   // Default number of octave cells in the chain.
   localparam int MAX_OCTAVES_DEF = 8;

   // Field widths of the words on the ports.
   localparam int COORD_W    = 32;
   localparam int NOISE_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Internal formats: frequency is unsigned Q32.16, amplitude unsigned Q1.16.
   localparam int FREQ_W = 48;
   localparam int AMP_W  = 17;

   // Quotient bits of the normalizing divide; the magnitude never exceeds 1.0.
   localparam int QUOT_W = 17;
   localparam logic [QUOT_W-1:0] MAG_LIMIT = 17'd32768;

   localparam logic [FREQ_W-1:0] FREQ_ONE = 48'd65536;
   localparam logic [AMP_W-1:0]  AMP_ONE  = 17'd65536;

   // Configuration as seen by the octave cells.
   typedef struct packed {
      logic [31:0] base_seed;
      logic [3:0]  octave_count;
      logic [15:0] lacunarity;
      logic [15:0] gain;
      logic        ridge_mode;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/fvn_octave_cell.sv =====
// One octave cell: scales the point, hashes four corners, blends and accumulates.
`default_nettype none

module fvn_octave_cell #(
   parameter int OCT_INDEX = 0,
   parameter int SUM_W     = 36,
   parameter int NORM_W    = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  fvn_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   input  logic signed [fvn_pkg::COORD_W-1:0] in_x,
   input  logic signed [fvn_pkg::COORD_W-1:0] in_z,
   input  logic [fvn_pkg::FREQ_W-1:0]        in_freq,
   input  logic [fvn_pkg::AMP_W-1:0]         in_amp,
   input  logic signed [SUM_W-1:0]           in_sum,
   input  logic [NORM_W-1:0]                 in_norm,
   output logic                              out_valid,
   output logic signed [fvn_pkg::COORD_W-1:0] out_x,
   output logic signed [fvn_pkg::COORD_W-1:0] out_z,
   output logic [fvn_pkg::FREQ_W-1:0]        out_freq,
   output logic [fvn_pkg::AMP_W-1:0]         out_amp,
   output logic signed [SUM_W-1:0]           out_sum,
   output logic [NORM_W-1:0]                 out_norm
);
   import fvn_pkg::*;

   localparam int DEPTH = 9;
   localparam logic [31:0] HASH_KX = 32'd374761393;
   localparam logic [31:0] HASH_KZ = 32'd668265263;
   localparam logic [31:0] HASH_KS = 32'd1442695041;
   localparam logic [31:0] HASH_KM = 32'd1274126177;
   localparam logic [31:0] SEED_OFS_PLAIN = 32'(OCT_INDEX * 1987);
   localparam logic [31:0] SEED_OFS_RIDGE = 32'(OCT_INDEX * 3571);
   localparam logic [17:0] THREE_ONE = 18'd196608;

   function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] s);
      logic [16:0] oms;
      logic [32:0] acc;
      oms   = 17'h10000 - {1'b0, s};
      acc   = a * oms + b * s;
      blend = acc[31:16];
   endfunction

   function automatic logic [31:0] mix13(input logic [31:0] h);
      mix13 = h ^ (h >> 13);
   endfunction

   logic act;
   assign act = 5'(OCT_INDEX) < {1'b0, cfg.octave_count};

   // Words carried alongside the octave arithmetic, one entry per stage.
   logic                       valid_ff [DEPTH];
   logic                       valid_in [DEPTH];
   logic signed [COORD_W-1:0]  x_ff     [DEPTH];
   logic signed [COORD_W-1:0]  x_in     [DEPTH];
   logic signed [COORD_W-1:0]  z_ff     [DEPTH];
   logic signed [COORD_W-1:0]  z_in     [DEPTH];
   logic [AMP_W-1:0]           amp_ff   [DEPTH];
   logic [AMP_W-1:0]           amp_in   [DEPTH];
   logic [FREQ_W-1:0]          nfreq_ff [DEPTH];
   logic [FREQ_W-1:0]          nfreq_in [DEPTH];
   logic [AMP_W-1:0]           namp_ff  [DEPTH];
   logic [AMP_W-1:0]           namp_in  [DEPTH];
   logic signed [SUM_W-1:0]    sum_ff   [DEPTH];
   logic signed [SUM_W-1:0]    sum_in   [DEPTH];
   logic [NORM_W-1:0]          norm_ff  [DEPTH];
   logic [NORM_W-1:0]          norm_in  [DEPTH];

   // Stage 1: partial products of the scaled coordinates.
   logic signed [56:0] pxl_ff, pxl_in, pzl_ff, pzl_in;
   logic signed [56:0] pxh_full, pzh_full;
   logic [39:0]        pxh_ff, pxh_in, pzh_ff, pzh_in;
   logic [63:0]        nfp;
   logic [32:0]        ampp;
   // Stage 2: cell index and fraction.
   logic [63:0] px, pz;
   logic [31:0] x0_ff, x0_in, z0_ff, z0_in;
   logic [15:0] tx_ff, tx_in, tz_ff, tz_in;
   // Stage 3: hash terms and smoothstep terms.
   logic [31:0] seed;
   logic [31:0] ax_ff, ax_in, az_ff, az_in, sk_ff, sk_in;
   logic [31:0] t2x_ff, t2x_in, t2z_ff, t2z_in;
   logic [17:0] kx_ff, kx_in, kz_ff, kz_in;
   // Stage 4: mixed corner hashes and smoothstep weights.
   logic [31:0] hbase;
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [49:0] spx, spz;
   logic [15:0] sx_ff, sx_in, sz_ff, sz_in;
   // Stage 5: corner values.
   logic [31:0] hm [4];
   logic [15:0] cv_ff [4];
   logic [15:0] cv_in [4];
   logic [15:0] sx5_ff, sx5_in, sz5_ff, sz5_in;
   // Stage 6: blend along x.
   logic [15:0] lo_ff, lo_in, hi_ff, hi_in, sz6_ff, sz6_in;
   // Stage 7: octave noise and ridge base.
   logic [15:0]        v;
   logic signed [15:0] n_ff, n_in;
   logic [15:0]        r_ff, r_in;
   // Stage 8: octave contribution.
   logic [31:0]        rr;
   logic signed [16:0] c_ff, c_in;
   // Stage 9: weighted contribution.
   logic signed [34:0] prod;

   always_comb begin
      nfp  = in_freq * cfg.lacunarity;
      ampp = in_amp * cfg.gain;
      valid_in[0] = in_valid;
      x_in[0]     = in_x;
      z_in[0]     = in_z;
      amp_in[0]   = in_amp;
      nfreq_in[0] = (|nfp[63:60]) ? {FREQ_W{1'b1}} : nfp[59:12];
      namp_in[0]  = ampp[32:16];
      sum_in[0]   = in_sum;
      norm_in[0]  = in_norm;
      prod = c_ff * $signed({1'b0, amp_ff[DEPTH-2]});
      for (int k = 1; k < DEPTH; k++) begin
         valid_in[k] = valid_ff[k-1];
         x_in[k]     = x_ff[k-1];
         z_in[k]     = z_ff[k-1];
         amp_in[k]   = amp_ff[k-1];
         nfreq_in[k] = nfreq_ff[k-1];
         namp_in[k]  = namp_ff[k-1];
         sum_in[k]   = sum_ff[k-1];
         norm_in[k]  = norm_ff[k-1];
      end
      // Only active octaves add to the running sums.
      if (act) begin
         sum_in[DEPTH-1]  = sum_ff[DEPTH-2] + SUM_W'(prod);
         norm_in[DEPTH-1] = norm_ff[DEPTH-2] + NORM_W'(amp_ff[DEPTH-2]);
      end
   end

   always_comb begin
      // Stage 1
      pxl_in   = $signed(in_x) * $signed({1'b0, in_freq[23:0]});
      pzl_in   = $signed(in_z) * $signed({1'b0, in_freq[23:0]});
      pxh_full = $signed(in_x) * $signed({1'b0, in_freq[47:24]});
      pzh_full = $signed(in_z) * $signed({1'b0, in_freq[47:24]});
      pxh_in   = pxh_full[39:0];
      pzh_in   = pzh_full[39:0];
      // Stage 2: the product is kept modulo 2^64, so the cell index wraps.
      px    = {{7{pxl_ff[56]}}, pxl_ff} + {pxh_ff, 24'd0};
      pz    = {{7{pzl_ff[56]}}, pzl_ff} + {pzh_ff, 24'd0};
      x0_in = px[63:32];
      z0_in = pz[63:32];
      tx_in = px[31:16];
      tz_in = pz[31:16];
      // Stage 3
      seed   = cfg.base_seed + (cfg.ridge_mode ? SEED_OFS_RIDGE : SEED_OFS_PLAIN);
      ax_in  = x0_ff * HASH_KX;
      az_in  = z0_ff * HASH_KZ;
      sk_in  = seed * HASH_KS;
      t2x_in = tx_ff * tx_ff;
      t2z_in = tz_ff * tz_ff;
      kx_in  = THREE_ONE - {1'b0, tx_ff, 1'b0};
      kz_in  = THREE_ONE - {1'b0, tz_ff, 1'b0};
      // Stage 4: the next corner along an axis adds the hash constant once more.
      hbase   = ax_ff + az_ff;
      h_in[0] = mix13(hbase ^ sk_ff);
      h_in[1] = mix13((hbase + HASH_KX) ^ sk_ff);
      h_in[2] = mix13((hbase + HASH_KZ) ^ sk_ff);
      h_in[3] = mix13((hbase + HASH_KX + HASH_KZ) ^ sk_ff);
      spx     = t2x_ff * kx_ff;
      spz     = t2z_ff * kz_ff;
      sx_in   = spx[47:32];
      sz_in   = spz[47:32];
      // Stage 5: the final xor-shift leaves the top half unchanged.
      for (int j = 0; j < 4; j++) begin
         hm[j]    = h_ff[j] * HASH_KM;
         cv_in[j] = hm[j][31:16];
      end
      sx5_in = sx_ff;
      sz5_in = sz_ff;
      // Stage 6
      lo_in  = blend(cv_ff[0], cv_ff[1], sx5_ff);
      hi_in  = blend(cv_ff[2], cv_ff[3], sx5_ff);
      sz6_in = sz5_ff;
      // Stage 7: subtracting one half flips the top bit.
      v    = blend(lo_ff, hi_ff, sz6_ff);
      n_in = {~v[15], v[14:0]};
      r_in = v[15] ? 16'(17'h10000 - {1'b0, v}) : v;
      // Stage 8
      rr   = r_ff * r_ff;
      c_in = cfg.ridge_mode ? $signed({1'b0, rr[30:15]}) : {n_ff[15], n_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k < DEPTH; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
      if (adv) begin
         for (int k = 0; k < DEPTH; k++) begin
            x_ff[k]     <= x_in[k];
            z_ff[k]     <= z_in[k];
            amp_ff[k]   <= amp_in[k];
            nfreq_ff[k] <= nfreq_in[k];
            namp_ff[k]  <= namp_in[k];
            sum_ff[k]   <= sum_in[k];
            norm_ff[k]  <= norm_in[k];
         end
         pxl_ff <= pxl_in;
         pzl_ff <= pzl_in;
         pxh_ff <= pxh_in;
         pzh_ff <= pzh_in;
         x0_ff  <= x0_in;
         z0_ff  <= z0_in;
         tx_ff  <= tx_in;
         tz_ff  <= tz_in;
         ax_ff  <= ax_in;
         az_ff  <= az_in;
         sk_ff  <= sk_in;
         t2x_ff <= t2x_in;
         t2z_ff <= t2z_in;
         kx_ff  <= kx_in;
         kz_ff  <= kz_in;
         for (int j = 0; j < 4; j++) begin
            h_ff[j]  <= h_in[j];
            cv_ff[j] <= cv_in[j];
         end
         sx_ff  <= sx_in;
         sz_ff  <= sz_in;
         sx5_ff <= sx5_in;
         sz5_ff <= sz5_in;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         sz6_ff <= sz6_in;
         n_ff   <= n_in;
         r_ff   <= r_in;
         c_ff   <= c_in;
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_x     = x_ff[DEPTH-1];
   assign out_z     = z_ff[DEPTH-1];
   assign out_freq  = nfreq_ff[DEPTH-1];
   assign out_amp   = namp_ff[DEPTH-1];
   assign out_sum   = sum_ff[DEPTH-1];
   assign out_norm  = norm_ff[DEPTH-1];

`ifndef ASSERT_OFF
   a_ridge_base_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> r_ff <= 16'h8000)
      else $error("ridge base out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/fvn_div_pipe.sv =====
// Pipelined restoring divider: weighted sum over amplitude sum, one quotient bit per stage.
`default_nettype none

module fvn_div_pipe #(
   parameter int SUM_W  = 36,
   parameter int NORM_W = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic signed [SUM_W-1:0]     in_sum,
   input  logic [NORM_W-1:0]           in_norm,
   output logic                        out_valid,
   output logic [fvn_pkg::QUOT_W-1:0]  out_quot,
   output logic                        out_neg,
   output logic                        out_zero
);
   import fvn_pkg::*;

   localparam int QB    = QUOT_W;
   localparam int CMP_W = (SUM_W > NORM_W + QB) ? SUM_W : NORM_W + QB;

   logic              valid_ff [QB+1];
   logic              valid_in [QB+1];
   logic [CMP_W-1:0]  rem_ff   [QB+1];
   logic [CMP_W-1:0]  rem_in   [QB+1];
   logic [NORM_W-1:0] norm_ff  [QB+1];
   logic [NORM_W-1:0] norm_in  [QB+1];
   logic [QB-1:0]     q_ff     [QB+1];
   logic [QB-1:0]     q_in     [QB+1];
   logic              neg_ff   [QB+1];
   logic              neg_in   [QB+1];
   logic              zero_ff  [QB+1];
   logic              zero_in  [QB+1];

   logic [SUM_W-1:0] mag;
   logic [CMP_W-1:0] dsh;
   logic             ge;

   always_comb begin
      mag = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : in_sum;
      valid_in[0] = in_valid;
      rem_in[0]   = CMP_W'(mag);
      norm_in[0]  = in_norm;
      q_in[0]     = '0;
      neg_in[0]   = in_sum[SUM_W-1];
      zero_in[0]  = (in_norm == '0);
      dsh = '0;
      ge  = 1'b0;
      // Stage k settles quotient bit QB-k.
      for (int k = 1; k <= QB; k++) begin
         dsh = CMP_W'(norm_ff[k-1]) << (QB - k);
         ge  = rem_ff[k-1] >= dsh;
         valid_in[k] = valid_ff[k-1];
         rem_in[k]   = ge ? rem_ff[k-1] - dsh : rem_ff[k-1];
         norm_in[k]  = norm_ff[k-1];
         q_in[k]     = {q_ff[k-1][QB-2:0], ge};
         neg_in[k]   = neg_ff[k-1];
         zero_in[k]  = zero_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k <= QB; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
      if (adv) begin
         for (int k = 0; k <= QB; k++) begin
            rem_ff[k]  <= rem_in[k];
            norm_ff[k] <= norm_in[k];
            q_ff[k]    <= q_in[k];
            neg_ff[k]  <= neg_in[k];
            zero_ff[k] <= zero_in[k];
         end
      end
   end

   assign out_valid = valid_ff[QB];
   assign out_quot  = q_ff[QB];
   assign out_neg   = neg_ff[QB];
   assign out_zero  = zero_ff[QB];

`ifndef ASSERT_OFF
   a_quot_bounded: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_zero |-> out_quot <= MAG_LIMIT)
      else $error("normalized magnitude above one");
`endif

endmodule

`default_nettype wire

// ===== rtl/fractal_value_noise_2d.sv =====
// Top level of the 2D fractal value noise block: config, octave cell chain, divider, output.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+--------------------------------
//   req       | in        | req_valid/req_stall  | req_coord_x, req_coord_z (Q16.16)
//   rsp       | out       | rsp_valid/rsp_stall  | rsp_noise_value (Q1.15)
//   csr       | in        | csr_write            | csr_index, csr_data
//
// One word is accepted per cycle while req_stall is low. A word passes in order
// through the MAX_OCTAVES octave cells, then the divider, which settles one
// quotient bit per stage, and last the output register.
// Reset is synchronous and active high; it restores the register defaults and
// empties the pipeline. The whole pipeline holds while a finished word waits on a
// stalled output, but bubbles still move up, so new words are taken until the
// last stage before the output register is full.
`default_nettype none

module fractal_value_noise_2d #(
   parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fvn_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [fvn_pkg::COORD_W-1:0]   req_coord_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fvn_pkg::NOISE_W-1:0]   rsp_noise_value,
   input  logic                                 csr_write,
   input  logic [fvn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fvn_pkg::CSR_DATA_W-1:0]       csr_data
);
   import fvn_pkg::*;

   // Sum of amplitude-weighted contributions is Q.31 and grows one bit per doubling
   // of the octave count; the amplitude sum is Q.16 and grows the same way.
   localparam int SUM_W  = 32 + $clog2(MAX_OCTAVES + 1);
   localparam int NORM_W = 16 + $clog2(MAX_OCTAVES + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_SEED    = 3'd0,
      CSR_OCTAVE_COUNT = 3'd1,
      CSR_LACUNARITY   = 3'd2,
      CSR_GAIN         = 3'd3,
      CSR_RIDGE_MODE   = 3'd4
   } csr_reg_type;

   // Configuration registers. Writes to an index past the list are dropped.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BASE_SEED:    cfg_in.base_seed    = csr_data;
            CSR_OCTAVE_COUNT: cfg_in.octave_count = csr_data[3:0];
            CSR_LACUNARITY:   cfg_in.lacunarity   = csr_data[15:0];
            CSR_GAIN:         cfg_in.gain         = csr_data[15:0];
            CSR_RIDGE_MODE:   cfg_in.ridge_mode   = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_seed    <= 32'd0;
         cfg_ff.octave_count <= 4'd5;
         cfg_ff.lacunarity   <= 16'd8192;
         cfg_ff.gain         <= 16'd32768;
         cfg_ff.ridge_mode   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output register state, needed by the flow control below.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [NOISE_W-1:0] rsp_value_ff, rsp_value_in;

   // Flow control. The output register takes a word when it is empty or being
   // read; the pipeline moves on then, and also whenever its last stage is a
   // bubble, since nothing would be lost.
   logic fin_valid;
   logic take;
   logic adv;

   assign take      = !rsp_valid_ff || !rsp_stall;
   assign adv       = take || !fin_valid;
   assign req_stall = !adv;

   // Octave chain. Entry 0 is the incoming word with frequency and amplitude at
   // one and empty sums; entry i+1 is what cell i hands on.
   logic                      ch_valid [MAX_OCTAVES+1];
   logic signed [COORD_W-1:0] ch_x     [MAX_OCTAVES+1];
   logic signed [COORD_W-1:0] ch_z     [MAX_OCTAVES+1];
   logic [FREQ_W-1:0]         ch_freq  [MAX_OCTAVES+1];
   logic [AMP_W-1:0]          ch_amp   [MAX_OCTAVES+1];
   logic signed [SUM_W-1:0]   ch_sum   [MAX_OCTAVES+1];
   logic [NORM_W-1:0]         ch_norm  [MAX_OCTAVES+1];

   assign ch_valid[0] = req_valid;
   assign ch_x[0]     = req_coord_x;
   assign ch_z[0]     = req_coord_z;
   assign ch_freq[0]  = FREQ_ONE;
   assign ch_amp[0]   = AMP_ONE;
   assign ch_sum[0]   = '0;
   assign ch_norm[0]  = '0;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
      fvn_octave_cell #(
         .OCT_INDEX (i),
         .SUM_W     (SUM_W),
         .NORM_W    (NORM_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .cfg       (cfg_ff),
         .in_valid  (ch_valid[i]),
         .in_x      (ch_x[i]),
         .in_z      (ch_z[i]),
         .in_freq   (ch_freq[i]),
         .in_amp    (ch_amp[i]),
         .in_sum    (ch_sum[i]),
         .in_norm   (ch_norm[i]),
         .out_valid (ch_valid[i+1]),
         .out_x     (ch_x[i+1]),
         .out_z     (ch_z[i+1]),
         .out_freq  (ch_freq[i+1]),
         .out_amp   (ch_amp[i+1]),
         .out_sum   (ch_sum[i+1]),
         .out_norm  (ch_norm[i+1])
      );
   end

   // Normalization: magnitude of the weighted sum over the amplitude sum.
   logic [QUOT_W-1:0] dv_quot;
   logic              dv_neg;
   logic              dv_zero;

   fvn_div_pipe #(
      .SUM_W  (SUM_W),
      .NORM_W (NORM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ch_valid[MAX_OCTAVES]),
      .in_sum    (ch_sum[MAX_OCTAVES]),
      .in_norm   (ch_norm[MAX_OCTAVES]),
      .out_valid (fin_valid),
      .out_quot  (dv_quot),
      .out_neg   (dv_neg),
      .out_zero  (dv_zero)
   );

   // Sign and saturation. With no octave summed the result is zero; a positive
   // result of exactly one clips to the largest Q1.15 value.
   logic signed [NOISE_W-1:0] result;

   always_comb begin
      if (dv_zero) begin
         result = '0;
      end else if (dv_neg) begin
         result = (dv_quot > MAG_LIMIT) ? 16'sh8000 : NOISE_W'(17'd0 - dv_quot);
      end else begin
         result = (dv_quot >= MAG_LIMIT) ? 16'sh7FFF : dv_quot[NOISE_W-1:0];
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = take ? fin_valid : rsp_valid_ff;
      rsp_value_in = (take && fin_valid) ? result : rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

`ifndef ASSERT_OFF
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");

   a_held_when_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(fin_valid))
      else $error("pipeline moved while frozen");

   a_output_from_pipeline: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(fin_valid))
      else $error("output word without a finished word");
`endif

endmodule

`default_nettype wire

// ===== tb/fractal_value_noise_2d_tb.sv =====
// Self-checking testbench of the fractal value noise block: directed table, then random words.
`default_nettype none

module fractal_value_noise_2d_tb;
   import fvn_pkg::*;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_SEED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OCTAVES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LACUN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RIDGE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NONE    = 3'd7;
   localparam int OCT_LIMIT = MAX_OCTAVES_DEF;
   // Cycles a word spends in the block, plus some margin for the settling pause.
   localparam int SETTLE = 9 * MAX_OCTAVES_DEF + 19 + 10;
   localparam int N_RANDOM = 700;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [NOISE_W-1:0] rsp_noise_value;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   fractal_value_noise_2d i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The predictor keeps its own copy of the registers.
   cfg_type shadow_cfg;

   // Expected noise words in order of acceptance.
   logic signed [NOISE_W-1:0] expected_noise[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int ridge_words = 0;
   bit rsp_stall_busy = 1'b0;

   function automatic logic [15:0] lattice_value(logic [31:0] cx, logic [31:0] cz,
                                                 logic [31:0] seed);
      logic [31:0] h;
      h = (cx * 32'd374761393 + cz * 32'd668265263) ^ (seed * 32'd1442695041);
      h = (h ^ (h >> 13)) * 32'd1274126177;
      h = h ^ (h >> 16);
      return h[31:16];
   endfunction

   function automatic logic [15:0] ease_curve(logic [15:0] t);
      logic [63:0] t2;
      logic [63:0] k;
      logic [63:0] p;
      t2 = 64'(t) * 64'(t);
      k = 64'd196608 - 64'd2 * 64'(t);
      p = t2 * k;
      return p[47:32];
   endfunction

   function automatic logic [31:0] mix_q16(logic [31:0] a, logic [31:0] b, logic [15:0] s);
      logic [63:0] v;
      v = 64'(a) * (64'd65536 - 64'(s)) + 64'(b) * 64'(s);
      return v[47:16];
   endfunction

   // One octave of lattice noise in Q1.15.
   function automatic int signed octave_value(logic [63:0] xs, logic [63:0] zs,
                                              logic [63:0] freq, logic [31:0] seed);
      logic [63:0] px;
      logic [63:0] pz;
      logic [31:0] x0;
      logic [31:0] z0;
      logic [15:0] sx;
      logic [15:0] sz;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] v;
      px = xs * freq;
      pz = zs * freq;
      x0 = px[63:32];
      z0 = pz[63:32];
      sx = ease_curve(px[31:16]);
      sz = ease_curve(pz[31:16]);
      lo = mix_q16(lattice_value(x0, z0, seed), lattice_value(x0 + 1, z0, seed), sx);
      hi = mix_q16(lattice_value(x0, z0 + 1, seed), lattice_value(x0 + 1, z0 + 1, seed), sx);
      v = mix_q16(lo, hi, sz);
      return int'(v) - 32768;
   endfunction

   function automatic logic signed [NOISE_W-1:0] fbm_noise(logic signed [31:0] x,
                                                           logic signed [31:0] z);
      logic [63:0] xs;
      logic [63:0] zs;
      logic [63:0] freq;
      logic [63:0] amp;
      logic [63:0] nf;
      logic [63:0] mag;
      logic [63:0] q;
      logic [31:0] step;
      logic [31:0] r;
      longint signed total;
      longint signed contrib;
      longint signed res;
      logic [63:0] norm;
      int signed n;
      int count;
      xs = 64'(x);
      zs = 64'(z);
      freq = 64'd65536;
      amp = 64'd65536;
      total = 0;
      norm = 0;
      res = 0;
      count = shadow_cfg.octave_count;
      step = shadow_cfg.ridge_mode ? 32'd3571 : 32'd1987;
      if (count > OCT_LIMIT) count = OCT_LIMIT;
      for (int i = 0; i < count; i++) begin
         n = octave_value(xs, zs, freq, shadow_cfg.base_seed + 32'(i) * step);
         if (shadow_cfg.ridge_mode) begin
            r = 32'd32768 - 32'(n < 0 ? -n : n);
            contrib = longint'((64'(r) * 64'(r)) >> 15);
         end else begin
            contrib = n;
         end
         total += contrib * longint'(amp);
         norm += amp;
         nf = (freq * 64'(shadow_cfg.lacunarity)) >> 12;
         freq = (nf > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : nf;
         amp = (amp * 64'(shadow_cfg.gain)) >> 16;
      end
      if (norm != 0) begin
         mag = (total < 0) ? 64'(-total) : 64'(total);
         q = mag / norm;
         res = (total < 0) ? -longint'(q) : longint'(q);
         if (res > 32767) res = 32767;
         if (res < -32768) res = -32768;
      end
      return res[15:0];
   endfunction

   // Register write, applied to the shadow copy at the same edge as the block.
   // The task then idles with the write strobe low, so the next write starts in a later time step.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_SEED:    shadow_cfg.base_seed = value;
         REG_OCTAVES: shadow_cfg.octave_count = value[3:0];
         REG_LACUN:   shadow_cfg.lacunarity = value[15:0];
         REG_GAIN:    shadow_cfg.gain = value[15:0];
         REG_RIDGE:   shadow_cfg.ridge_mode = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Drive one word and hold it until the block takes it. The expectation is queued
   // at the accepting edge so it is in place before the result can appear. Valid is
   // left high so a following word can go back to back; an idle gap, drain or pause
   // drops it.
   task automatic send_word(logic signed [31:0] x, logic signed [31:0] z);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_z <= z;
      do @(posedge clock); while (req_stall);
      expected_noise.push_back(fbm_noise(x, z));
      words_sent++;
      if (shadow_cfg.ridge_mode) ridge_words++;
   endtask

   // Wait until every expected word is back, then let the pipeline run dry.
   task automatic drain;
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_noise.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // Output side: random stall each cycle while busy, with calm stretches.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_stall_busy) begin
            rsp_stall <= ($urandom_range(0, 9) < 4);
         end else begin
            rsp_stall <= 1'b0;
         end
         if (($urandom_range(0, 199)) == 0) rsp_stall_busy <= ~rsp_stall_busy;
      end
   end

   // Compare each accepted noise word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_noise.size() == 0) begin
            $error("unexpected noise word %0d", rsp_noise_value);
            errors++;
         end else begin
            logic signed [NOISE_W-1:0] want;
            want = expected_noise.pop_front();
            words_checked++;
            if (rsp_noise_value !== want) begin
               $error("noise_value: expected %0d, got %0d", want, rsp_noise_value);
               errors++;
            end
         end
      end
   end

   // One row of the directed table: a configuration to apply, then a sample point.
   typedef struct {
      logic [31:0] seed;
      logic [3:0]  octaves;
      logic [15:0] lacun;
      logic [15:0] gn;
      logic        ridge;
      logic signed [31:0] x;
      logic signed [31:0] z;
   } stim_row_type;

   stim_row_type directed_rows[] = '{
      '{32'd0, 4'd5, 16'd8192, 16'd32768, 1'b0, 32'sd0, 32'sd0},
      '{32'd0, 4'd5, 16'd8192, 16'd32768, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000},
      '{32'd0, 4'd5, 16'd8192, 16'd32768, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF},
      '{32'd0, 4'd5, 16'd8192, 16'd32768, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'hFFFF_FFFF, 4'd1, 16'd4096, 16'd65535, 1'b0, 32'h0001_8000, 32'hFFFE_8000},
      '{32'hFFFF_FFFF, 4'd8, 16'd65535, 16'd65535, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0},
      '{32'h0000_1234, 4'd15, 16'd65535, 16'd0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'h0000_1234, 4'd8, 16'd0, 16'd40000, 1'b0, 32'h0003_0000, 32'h0005_0000},
      '{32'hDEAD_BEEF, 4'd8, 16'd65535, 16'd65535, 1'b1, 32'h4000_0000, 32'hC000_0000},
      '{32'hDEAD_BEEF, 4'd4, 16'd8192, 16'd32768, 1'b1, 32'h0000_8000, 32'h0000_8000},
      '{32'd7, 4'd1, 16'd8192, 16'd0, 1'b1, 32'h0000_0000, 32'h0001_0000},
      '{32'd7, 4'd12, 16'd12288, 16'd50000, 1'b1, 32'hFFFF_0000, 32'h0000_FFFF},
      '{32'd0, 4'd5, 16'd8192, 16'd32768, 1'b0, 32'h0000_FFFF, 32'hFFFF_0001}
   };

   int random_left;
   bit paused_once;

   initial begin
      shadow_cfg = '{base_seed: 32'd0, octave_count: 4'd5, lacunarity: 16'd8192,
                     gain: 16'd32768, ridge_mode: 1'b0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Right after reset the defaults hold; the first row checks them.
      send_word(directed_rows[0].x, directed_rows[0].z);
      drain();

      // Zero octaves sum nothing and give an exact zero; checked as a typed-in value.
      write_reg(REG_OCTAVES, 32'd0);
      send_word(32'h1111_2222, 32'h3333_4444);
      if (expected_noise[$] !== 16'sd0) begin
         $error("noise_value: expected %0d, got %0d", 0, expected_noise[$]);
         errors++;
      end
      drain();
      // An index past the last register must change nothing.
      write_reg(REG_NONE, 32'hFFFF_FFFF);

      foreach (directed_rows[i]) begin
         if (i != 0) begin
            drain();
            write_reg(REG_SEED, directed_rows[i].seed);
            write_reg(REG_OCTAVES, 32'(directed_rows[i].octaves));
            write_reg(REG_LACUN, 32'(directed_rows[i].lacun));
            write_reg(REG_GAIN, 32'(directed_rows[i].gn));
            write_reg(REG_RIDGE, 32'(directed_rows[i].ridge));
            send_word(directed_rows[i].x, directed_rows[i].z);
         end
      end

      // Random phases: each phase picks a fresh setting, then streams points.
      random_left = N_RANDOM;
      paused_once = 1'b0;
      while (random_left > 0) begin
         int burst;
         drain();
         write_reg(REG_SEED, $urandom);
         write_reg(REG_OCTAVES, 32'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                             : $urandom_range(1, 8)));
         write_reg(REG_LACUN, 32'($urandom_range(0, 1) ? $urandom_range(4096, 12288)
                                                       : $urandom_range(0, 65535)));
         write_reg(REG_GAIN, 32'($urandom_range(0, 65535)));
         write_reg(REG_RIDGE, 32'($urandom_range(0, 1)));
         burst = $urandom_range(20, 80);
         for (int k = 0; k < burst && random_left > 0; k++) begin
            logic signed [31:0] x;
            logic signed [31:0] z;
            // Mostly moderate coordinates, with the full range mixed in.
            if ($urandom_range(0, 3) == 0) begin
               x = $urandom;
               z = $urandom;
            end else begin
               x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
               z = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            end
            send_word(x, z);
            random_left--;
            // Hold the sender off until everything in flight has come back.
            if (!paused_once && k == 10) begin
               req_valid <= 1'b0;
               while (expected_noise.size() != 0) @(posedge clock);
               paused_once = 1'b1;
            end
         end
      end

      drain();
      $display("Sent %0d sample words (%0d in ridged mode), checked %0d noise words,",
               words_sent, ridge_words, words_checked);
      $display("covering table corners and random settings of all five registers.");
      if (errors == 0 && expected_noise.size() == 0) begin
         $display("fractal_value_noise_2d_tb: done, clean");
      end else begin
         if (expected_noise.size() != 0)
            $error("%0d noise words never arrived", expected_noise.size());
         $display("fractal_value_noise_2d_tb: done, errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("fractal_value_noise_2d_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
